// ===== src/sliding_window_burst_detector_macros.svh =====
// Assertion macros shared by the sliding window burst detector RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef SLIDING_WINDOW_BURST_DETECTOR_MACROS_SVH
`define SLIDING_WINDOW_BURST_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/swbd_pkg.sv =====
// Package for the sliding window burst detector: cell operations, control
// state type, chain control struct and the saturating age helper. No dependencies.
`default_nettype none

package swbd_pkg;

  localparam int STAMP_W  = 64;
  localparam int WINDOW_W = 32;
  localparam int THR_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int OUT_W    = 40;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WINDOW    = 2'd1;
  localparam logic [1:0] REG_HOLD      = 2'd2;

  // Input command codes.
  localparam logic CMD_EVENT   = 1'b0;
  localparam logic CMD_OBSERVE = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    cell_op_t           op;
    logic [STAMP_W-1:0] new_stamp;
  } chain_ctl_t;

  // Age of a stored time, zero when time appears to run backwards.
  function automatic logic [STAMP_W-1:0] age_of(input logic [STAMP_W-1:0] now,
                                                input logic [STAMP_W-1:0] then_t);
    logic [STAMP_W:0] diff;
    diff = {1'b0, now} - {1'b0, then_t};
    return diff[STAMP_W] ? '0 : diff[STAMP_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/swbd_cell.sv =====
// One timestamp cell of the detector chain: holds a stamp, loads it from the
// lower neighbor on a shift and from the upper neighbor on a rotate. Uses swbd_pkg.
`default_nettype none

module swbd_cell (
  input  wire logic                          clk,
  input  wire swbd_pkg::cell_op_t            op,
  input  wire logic [swbd_pkg::STAMP_W-1:0]  shift_in,
  input  wire logic [swbd_pkg::STAMP_W-1:0]  rot_in,
  output logic      [swbd_pkg::STAMP_W-1:0]  stamp_q
);
  import swbd_pkg::*;

  logic [STAMP_W-1:0] stamp_r;
  logic [STAMP_W-1:0] stamp_nxt;

  // Select the source of the next stamp.
  always_comb begin
    unique case (op)
      CELL_SHIFT:  stamp_nxt = shift_in;
      CELL_ROTATE: stamp_nxt = rot_in;
      default:     stamp_nxt = stamp_r;
    endcase
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    stamp_r <= stamp_nxt;
  end

  assign stamp_q = stamp_r;

endmodule

`default_nettype wire

// ===== src/swbd_chain.sv =====
// Row of timestamp cells with the fill count. Newest stamp sits in cell 0;
// a rotate brings the next older stamp to cell 0. Uses swbd_pkg and swbd_cell.
`default_nettype none

module swbd_chain #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire swbd_pkg::chain_ctl_t                ctl,
  output logic      [swbd_pkg::STAMP_W-1:0]        head,
  output logic      [$clog2(RING_DEPTH+1)-1:0]     fill
);
  import swbd_pkg::*;

  localparam int FW = $clog2(RING_DEPTH + 1);

  logic [STAMP_W-1:0] stamps [RING_DEPTH];
  logic [FW-1:0]      fill_r;
  logic [FW-1:0]      fill_nxt;

  // Cells: shift comes from the lower neighbor, rotate from the upper one.
  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    localparam int UP = (i + 1) % RING_DEPTH;
    logic [STAMP_W-1:0] shift_src;
    if (i == 0) begin : g_first
      assign shift_src = ctl.new_stamp;
    end else begin : g_rest
      assign shift_src = stamps[i-1];
    end
    swbd_cell u_cell (
      .clk      (clk),
      .op       (ctl.op),
      .shift_in (shift_src),
      .rot_in   (stamps[UP]),
      .stamp_q  (stamps[i])
    );
  end

  // Fill count saturates at the depth of the chain.
  always_comb begin
    fill_nxt = fill_r;
    if (ctl.op == CELL_SHIFT && fill_r != FW'(RING_DEPTH)) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign head = stamps[0];
  assign fill = fill_r;

endmodule

`default_nettype wire

// ===== src/sliding_window_burst_detector.sv =====
// Sliding window burst detector. An item is taken in the idle state (an
// event shifts its time into the cell chain there), then the chain rotates
// RING_DEPTH times so each stored time passes the single age comparator at
// cell 0, then the finish state evaluates the hold time and loads the output
// register, waiting while a previous result there has not been taken. A new
// item is accepted while a finished result still waits in the output
// register. Threshold writes are clamped to 1..RING_DEPTH. Depends on
// swbd_pkg, swbd_chain and the macros header.
`default_nettype none

`include "sliding_window_burst_detector_macros.svh"

module sliding_window_burst_detector #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_data,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [63:0] now_ms
  input  wire logic        in_tuser,   // [0] command
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // [0] tripped_now, [32:1] burst_span,
                                       // [37:33] recent_count, [38] flood_active, [39] zero
);
  import swbd_pkg::*;

  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int SW = $clog2(RING_DEPTH);
  localparam logic [THR_W-1:0] THR_RESET =
    (RING_DEPTH < 8) ? THR_W'(RING_DEPTH) : THR_W'(8);

  // Configuration registers.
  logic [THR_W-1:0]    thr_r;
  logic [WINDOW_W-1:0] window_r;
  logic [WINDOW_W-1:0] hold_r;
  logic [THR_W-1:0]    thr_clamped;

  // Control and walk state.
  state_t             state_r, state_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic               cmd_r;
  logic [STAMP_W-1:0] now_r;
  logic               run_r, run_nxt;
  logic [FW-1:0]      count_r, count_nxt;
  logic               trip_r, trip_nxt;
  logic [31:0]        span_r, span_nxt;
  logic               trip_latched_r, trip_latched_nxt;
  logic [STAMP_W-1:0] trip_time_r, trip_time_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  chain_ctl_t         chain_ctl;
  logic [STAMP_W-1:0] head;
  logic [FW-1:0]      fill;
  logic [STAMP_W-1:0] head_age;
  logic               head_young;
  logic               in_fill;
  logic               at_thr;
  logic               flood;
  logic               in_xfer;
  logic               out_xfer;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;

  // Threshold clamp on write.
  always_comb begin
    thr_clamped = cfg_data[THR_W-1:0];
    if (thr_clamped == '0) begin
      thr_clamped = THR_W'(1);
    end else if (32'(thr_clamped) > 32'(RING_DEPTH)) begin
      thr_clamped = THR_W'(RING_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RESET;
      window_r <= WINDOW_W'(1000);
      hold_r   <= WINDOW_W'(5000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_THRESHOLD: thr_r    <= thr_clamped;
        REG_WINDOW:    window_r <= cfg_data;
        REG_HOLD:      hold_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  swbd_chain #(
    .RING_DEPTH (RING_DEPTH)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (chain_ctl),
    .head  (head),
    .fill  (fill)
  );

  // Comparisons on the stamp now at the head of the chain.
  assign head_age   = age_of(now_r, head);
  assign head_young = head_age < {{(STAMP_W-WINDOW_W){1'b0}}, window_r};
  assign in_fill    = FW'(step_r) < fill;
  assign at_thr     = (32'(step_r) + 32'd1) == 32'(thr_r);
  assign flood      = trip_latched_r &&
                      (age_of(now_r, trip_time_r) < {{(STAMP_W-WINDOW_W){1'b0}}, hold_r});

  // Next state, chain control and walk bookkeeping.
  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    run_nxt          = run_r;
    count_nxt        = count_r;
    trip_nxt         = trip_r;
    span_nxt         = span_r;
    trip_latched_nxt = trip_latched_r;
    trip_time_nxt    = trip_time_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_data_nxt     = out_data_r;
    chain_ctl.op        = CELL_HOLD;
    chain_ctl.new_stamp = in_tdata;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == CMD_EVENT) begin
            chain_ctl.op = CELL_SHIFT;
          end
          state_nxt = ST_WALK;
          step_nxt  = '0;
          run_nxt   = 1'b1;
          count_nxt = '0;
          trip_nxt  = 1'b0;
          span_nxt  = '0;
        end
      end
      ST_WALK: begin
        chain_ctl.op = CELL_ROTATE;
        if (run_r && in_fill && head_young) begin
          count_nxt = count_r + 1'b1;
        end else begin
          run_nxt = 1'b0;
        end
        if (cmd_r == CMD_EVENT && at_thr && in_fill && head_young) begin
          trip_nxt         = 1'b1;
          span_nxt         = head_age[31:0];
          trip_latched_nxt = 1'b1;
          trip_time_nxt    = now_r;
        end
        if (step_r == SW'(RING_DEPTH - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, flood, COUNT_W'(count_r), span_r, trip_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      trip_latched_r <= 1'b0;
      trip_time_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      trip_latched_r <= trip_latched_nxt;
      trip_time_r    <= trip_time_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Walk and payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r <= in_tdata;
      cmd_r <= in_tuser;
    end
    step_r     <= step_nxt;
    run_r      <= run_nxt;
    count_r    <= count_nxt;
    trip_r     <= trip_nxt;
    span_r     <= span_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A fresh trip is always inside a nonzero hold time.
  `SWBD_ASSERT_SAME(a_trip_flood, clk, rst_n,
    out_tvalid && out_tdata[0] && hold_r != '0, out_tdata[38],
    "trip reported without an active flood")
  // Without a trip the span is zero.
  `SWBD_ASSERT_SAME(a_span_zero, clk, rst_n,
    out_tvalid && !out_tdata[0], out_tdata[32:1] == 32'd0,
    "nonzero burst span without a trip")
  // The walk ends after a full rotation of the chain.
  `SWBD_ASSERT_NEXT(a_walk_end, clk, rst_n,
    state_r == ST_WALK && step_r == SW'(RING_DEPTH - 1), state_r == ST_FINISH,
    "walk did not end after a full rotation")
  // The fill count never exceeds the chain depth.
  `SWBD_ASSERT_SAME(a_fill_max, clk, rst_n, 1'b1, 32'(fill) <= 32'(RING_DEPTH),
    "fill count above the chain depth")

endmodule

`default_nettype wire
